// File: rtl/core/audio_fifo_clock_adapter_top_assert.svh
// assertion macros for the audio fifo clock adapter
`ifndef AUDIO_FIFO_CLOCK_ADAPTER_TOP_ASSERT_SVH
`define AUDIO_FIFO_CLOCK_ADAPTER_TOP_ASSERT_SVH

// a condition that must hold at every clock edge out of reset
`define AFCA_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// an antecedent that implies a consequent in the next cycle
`define AFCA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/afca_pkg.sv
// ----------------------------------------------------------------------------
// afca_pkg
// shared types and constants of the audio fifo clock adapter
// ----------------------------------------------------------------------------
package afca_pkg;
	localparam int RING_DEPTH = 4096;
	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam int CNT_W = PTR_W + 1;
	localparam int MAX_BLOCK = 63;
	localparam int BLK_W = 6;
	localparam int IDX_W = BLK_W + 1;
	localparam int QDEPTH = 2;

	localparam logic [1:0] CMD_PUSH = 2'd0;
	localparam logic [1:0] CMD_PULL = 2'd1;
	localparam logic [1:0] CMD_ACT  = 2'd2;

	localparam logic [1:0] DIR_IDLE = 2'd0;
	localparam logic [1:0] DIR_DROP = 2'd1;
	localparam logic [1:0] DIR_DUP  = 2'd2;

	localparam logic [1:0] REG_TARGET  = 2'd0;
	localparam logic [1:0] REG_ENGAGE  = 2'd1;
	localparam logic [1:0] REG_RELEASE = 2'd2;
	localparam logic [1:0] REG_SHIFT   = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] frame;
		logic [5:0]  blk;
		logic        act;
	} cmd_t;
endpackage

// File: rtl/core/afca_front.sv
// ----------------------------------------------------------------------------
// afca_front
// command intake: drops unknown commands and queues the rest
// ----------------------------------------------------------------------------
module afca_front import afca_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  cmd_t in_cmd,
	output logic full,
	output logic q_valid,
	output cmd_t q_cmd,
	input  logic q_pop
);
	cmd_t       mem_q [QDEPTH];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign full = (cnt_q == 2'(QDEPTH));
	assign push = in_valid && (in_cmd.cmd == CMD_PUSH || in_cmd.cmd == CMD_PULL ||
		in_cmd.cmd == CMD_ACT);
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

`include "audio_fifo_clock_adapter_top_assert.svh"
	`AFCA_ASSERT_ALWAYS(a_no_overflow, !(push && full && !q_pop), "queue overflow")
	`AFCA_ASSERT_ALWAYS(a_no_underflow, !(q_pop && !q_valid), "queue underflow")
	`AFCA_ASSERT_ALWAYS(a_cnt_range, cnt_q <= 2'(QDEPTH), "queue count out of range")
endmodule

// File: rtl/core/afca_back.sv
// ----------------------------------------------------------------------------
// afca_back
// ring buffer, depth filter and block sequencer
// ----------------------------------------------------------------------------
module afca_back import afca_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  cmd_t        q_cmd,
	output logic        q_pop,
	output logic        idle,
	input  logic [11:0] target_depth,
	input  logic [11:0] engage_margin,
	input  logic [11:0] release_margin,
	input  logic [3:0]  filter_shift,
	output logic        strobe,
	output logic [31:0] frame,
	output logic        fvalid,
	output logic        last,
	output logic [1:0]  corr
);
	localparam logic [2:0] S_IDLE = 3'd0, S_FILT = 3'd1, S_DIR = 3'd2, S_READ = 3'd3,
		S_SCAN = 3'd4, S_EMIT = 3'd5, S_EMPTY = 3'd6;

	logic [2:0]       st_q;
	logic [31:0]      ring_q [RING_DEPTH];
	logic [31:0]      scr_q [MAX_BLOCK+1];
	logic [PTR_W-1:0] rp_q, wp_q;
	logic [CNT_W-1:0] fill_q;
	logic signed [CNT_W+1:0] sm_q;
	logic [1:0]       dir_q, corr_q;
	logic             act_q;
	logic [BLK_W-1:0] req_q, rdidx_q;
	logic [IDX_W-1:0] win_q, best_q, idx_q;
	logic [16:0]      bmag_q;
	logic             dup_q, rdv_q;
	logic [31:0]      rdat_q, sdat_q;
	logic             sv_q;

	logic signed [CNT_W+1:0] diff, shd, nsm;
	logic [CNT_W-1:0] depth;
	logic [16:0]      mag;
	logic [15:0]      al, ar;
	logic [BLK_W-1:0] wr_idx;
	logic             emit_skip, emit_fin;

	assign depth = fill_q;
	assign diff = $signed({2'b00, depth}) - sm_q;
	assign shd = diff >>> filter_shift;
	assign nsm = sm_q + shd;
	assign al = sdat_q[31] ? 16'(-sdat_q[31:16]) : sdat_q[31:16];
	assign ar = sdat_q[15] ? 16'(-sdat_q[15:0]) : sdat_q[15:0];
	assign mag = {1'b0, al} + {1'b0, ar};
	assign wr_idx = BLK_W'(idx_q - 7'd1);

	// dropped frame is skipped; last is held back on the first copy of a duplicate
	assign emit_skip = (corr_q == DIR_DROP) && idx_q == best_q;
	assign emit_fin = (idx_q == win_q - 7'd1) &&
		!(corr_q == DIR_DUP && idx_q == best_q && !dup_q);

	assign idle = (st_q == S_IDLE);
	assign q_pop = idle && q_valid;

	always_ff @(posedge clk) begin
		rdat_q <= ring_q[rp_q];
		sdat_q <= scr_q[rdidx_q];
		if (q_pop && q_cmd.cmd == CMD_PUSH && act_q) ring_q[wp_q] <= q_cmd.frame;
		if (rdv_q) scr_q[wr_idx] <= rdat_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; rp_q <= '0; wp_q <= '0; fill_q <= '0; sm_q <= '0;
			dir_q <= DIR_IDLE; act_q <= 1'b0; strobe <= 1'b0; rdv_q <= 1'b0;
			sv_q <= 1'b0; idx_q <= '0; rdidx_q <= '0; dup_q <= 1'b0;
			req_q <= '0; win_q <= '0; best_q <= '0; bmag_q <= '0;
			corr_q <= '0; frame <= '0; fvalid <= 1'b0; last <= 1'b0; corr <= '0;
		end else begin
			strobe <= (st_q == S_EMPTY) || (st_q == S_EMIT && sv_q && !emit_skip);
			rdv_q <= (st_q == S_READ) && (idx_q != win_q);
			unique case (st_q)
			S_IDLE: if (q_pop) begin
				unique case (q_cmd.cmd)
				CMD_PUSH: if (act_q) begin
					wp_q <= wp_q + 1'b1;
					if (fill_q == CNT_W'(RING_DEPTH)) rp_q <= rp_q + 1'b1;
					else fill_q <= fill_q + 1'b1;
				end
				CMD_PULL: begin
					req_q <= q_cmd.blk;
					corr_q <= DIR_IDLE;
					if (!act_q || q_cmd.blk == '0 ||
						(sm_q == '0 && depth < CNT_W'(target_depth))) st_q <= S_EMPTY;
					else if (depth == '0) begin
						sm_q <= '0; dir_q <= DIR_IDLE; st_q <= S_EMPTY;
					end else st_q <= S_FILT;
				end
				CMD_ACT: if (q_cmd.act != act_q) begin
					act_q <= q_cmd.act; sm_q <= '0; dir_q <= DIR_IDLE;
					rp_q <= wp_q; fill_q <= '0;
				end
				default: ;
				endcase
			end
			S_FILT: begin
				sm_q <= (nsm <= 0) ? (CNT_W+2)'(1) : nsm;
				st_q <= S_DIR;
			end
			S_DIR: begin
				logic signed [CNT_W+1:0] err, aerr;
				logic [1:0] nd;
				logic [BLK_W-1:0] wo;
				logic [IDX_W-1:0] wi;
				err = sm_q - $signed({2'b00, 1'b0, target_depth});
				aerr = err < 0 ? -err : err;
				nd = dir_q;
				if (dir_q == DIR_IDLE) begin
					if (err > $signed({2'b00, 1'b0, engage_margin})) nd = DIR_DROP;
					else if (err < -$signed({2'b00, 1'b0, engage_margin})) nd = DIR_DUP;
				end else if (aerr < $signed({2'b00, 1'b0, release_margin})) nd = DIR_IDLE;
				wo = (CNT_W'(req_q) < depth) ? req_q : BLK_W'(depth);
				wi = {1'b0, wo};
				// a drop of a full 63-frame block reads 64 frames
				if (nd == DIR_DROP && depth > CNT_W'(wo)) wi = {1'b0, wo} + 7'd1;
				else if (nd == DIR_DUP && wo > 6'd1) wi = {1'b0, wo} - 7'd1;
				dir_q <= nd; corr_q <= nd; win_q <= wi;
				idx_q <= '0; st_q <= S_READ;
			end
			S_READ: begin
				// one ring read per cycle, the registered data lands in scratch
				if (idx_q != win_q) begin
					rp_q <= rp_q + 1'b1; fill_q <= fill_q - 1'b1;
					idx_q <= idx_q + 7'd1;
				end else if (!rdv_q) begin
					best_q <= win_q - 7'd1; bmag_q <= '1; rdidx_q <= '0;
					idx_q <= '0; sv_q <= 1'b0;
					st_q <= (corr_q == DIR_IDLE) ? S_EMIT : S_SCAN;
				end
			end
			S_SCAN: begin
				// rdidx_q runs one entry ahead so sdat_q holds scratch[idx_q]
				if (sv_q && idx_q + 7'd1 == win_q) begin
					if (mag < bmag_q) best_q <= idx_q;
					sv_q <= 1'b0; idx_q <= '0; rdidx_q <= '0; dup_q <= 1'b0;
					st_q <= S_EMIT;
				end else begin
					if (sv_q) begin
						if (mag < bmag_q) begin
							bmag_q <= mag; best_q <= idx_q;
						end
						idx_q <= idx_q + 7'd1;
					end
					sv_q <= 1'b1;
					rdidx_q <= rdidx_q + 6'd1;
				end
			end
			S_EMIT: begin
				// sv_q marks that sdat_q holds scratch[idx_q]
				if (!sv_q) begin
					if (win_q == '0) st_q <= S_EMPTY;
					else sv_q <= 1'b1;
				end else begin
					if (!emit_skip) begin
						frame <= sdat_q; fvalid <= 1'b1; corr <= corr_q;
						last <= emit_fin || ((idx_q == win_q - 7'd2) && corr_q == DIR_DROP &&
							best_q == win_q - 7'd1);
					end
					if (corr_q == DIR_DUP && idx_q == best_q && !dup_q) dup_q <= 1'b1;
					else begin
						dup_q <= 1'b0;
						sv_q <= 1'b0;
						if (idx_q == win_q - 7'd1) begin
							if (emit_skip && win_q == 7'd1) st_q <= S_EMPTY;
							else st_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + 7'd1; rdidx_q <= BLK_W'(idx_q + 7'd1);
						end
					end
				end
			end
			S_EMPTY: begin
				frame <= '0; fvalid <= 1'b0; last <= 1'b1;
				corr <= corr_q; st_q <= S_IDLE;
			end
			default: st_q <= S_IDLE;
			endcase
		end
	end

`include "audio_fifo_clock_adapter_top_assert.svh"
	`AFCA_ASSERT_ALWAYS(a_fill_max, fill_q <= CNT_W'(RING_DEPTH), "fill above ring size")
	`AFCA_ASSERT_ALWAYS(a_inactive_empty, act_q || fill_q == '0, "data while inactive")
	`AFCA_ASSERT_NEXT(a_empty_last, st_q == S_EMPTY, strobe && last && !fvalid,
		"empty result malformed")
endmodule

// File: rtl/core/audio_fifo_clock_adapter_top.sv
// ----------------------------------------------------------------------------
// audio_fifo_clock_adapter_top
// stereo frame ring with prefill, depth averaging and drop/duplicate steering
// ----------------------------------------------------------------------------
// channel    direction  handshake
// command    in         start & !busy
// config     in         cfg_valid & cfg_ready
// result     out        result_strobe, one cycle, no backpressure
//
// a push or set-active retires when the idle back end pops it from the queue; an
// empty pull goes from the queue through the empty state to the registered result;
// a pull reading w frames runs the read and emit states, plus the scan state when
// steering seeks the quietest frame and a second copy for a duplicate, paced by the
// single ring read port and the scratch read port the scan and output walk share
// reset clears pointers, fill count, filter and active state at once
// the result side cannot stall; busy rises while the command queue is full
module audio_fifo_clock_adapter_top import afca_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic signed [15:0] sample_left,
	input  logic signed [15:0] sample_right,
	input  logic [5:0]  block_frames,
	input  logic        active_flag,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	output logic        result_strobe,
	output logic signed [15:0] out_left,
	output logic signed [15:0] out_right,
	output logic        frame_valid,
	output logic        last_of_block,
	output logic [1:0]  correction
);
	logic [11:0] target_q, engage_q, release_q;
	logic [3:0]  shift_q;
	cmd_t        in_cmd, q_cmd;
	logic        full, q_valid, q_pop, idle;
	logic [31:0] frame;

	assign cfg_ready = 1'b1;
	assign busy = full;
	assign in_cmd = '{cmd: command, frame: {sample_left, sample_right},
		blk: block_frames, act: active_flag};

	// register file; all four indexes are defined
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= 12'd480; engage_q <= 12'd192; release_q <= 12'd96; shift_q <= 4'd5;
		end else if (cfg_valid) begin
			unique case (cfg_index)
			REG_TARGET:  target_q <= cfg_data;
			REG_ENGAGE:  engage_q <= cfg_data;
			REG_RELEASE: release_q <= cfg_data;
			REG_SHIFT:   shift_q <= cfg_data[3:0];
			endcase
		end
	end

	afca_front u_front (.clk, .arst_n, .in_valid(start && !busy), .in_cmd, .full,
		.q_valid, .q_cmd, .q_pop);

	afca_back u_back (.clk, .arst_n, .q_valid, .q_cmd, .q_pop, .idle,
		.target_depth(target_q), .engage_margin(engage_q), .release_margin(release_q),
		.filter_shift(shift_q), .strobe(result_strobe), .frame, .fvalid(frame_valid),
		.last(last_of_block), .corr(correction));

	assign out_left = frame[31:16];
	assign out_right = frame[15:0];

`include "audio_fifo_clock_adapter_top_assert.svh"
	`AFCA_ASSERT_NEXT(a_idle_quiet, idle, !result_strobe, "result after idle cycle")
	`AFCA_ASSERT_ALWAYS(a_shift_range, shift_q <= 4'd15, "shift out of range")
	`AFCA_ASSERT_ALWAYS(a_empty_zero, frame_valid || !result_strobe || frame == '0,
		"empty result carries data")
endmodule
